// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define LCTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LCTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LCTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/lcta_pkg.sv =====
// Shared types and constants for the least-cost transport allocation block.
package lcta_pkg;
  localparam int MaxRows    = 16;
  localparam int MaxCols    = 16;
  localparam int AmountBits = 16;
  localparam int RowW       = 4;
  localparam int ColW       = 4;
  localparam int CellW      = RowW + ColW;
  localparam int DimW       = 5;
  localparam int TotalW     = 37;
  localparam int SumW       = AmountBits + DimW;

  localparam logic [1:0] KIND_COST   = 2'd0;
  localparam logic [1:0] KIND_SUPPLY = 2'd1;
  localparam logic [1:0] KIND_DEMAND = 2'd2;
  localparam logic [1:0] KIND_SOLVE  = 2'd3;

  localparam logic [1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [1:0] REG_NUM_COLS = 2'd1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [RowW-1:0]       row;
    logic [ColW-1:0]       col;
    logic [AmountBits-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [TotalW-1:0] total_cost;
    logic              status;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_CHECK, ST_INIT, ST_SCAN, ST_SCAN_LAST, ST_PICK,
    ST_MUL, ST_ACC, ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // write the accepted load request
    logic sum_clr;   // clear balance sums, counter, total, status and closed masks
    logic sum_step;  // add one supply and one demand
    logic init;      // copy stores to working copies, set open row and column counts
    logic scan_clr;  // start a scan round
    logic scan_step; // examine one cell
    logic pick;      // read chosen cell, update lines
    logic mul;       // register the product
    logic acc;       // add product to total
    logic unbal;     // latch unbalanced result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sum_done;
    logic balanced;
    logic scan_last;  // the cell being scanned is the last one
    logic found;
    logic open_any;   // at least one open row and one open column
  } sts_t;
endpackage

// ===== src/lcta_ctrl.sv =====
// Controller state machine for the solve sequence and the handshakes.
module lcta_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_kind,
  output logic           out_valid,
  input  logic           out_ready,
  input  lcta_pkg::sts_t sts,
  output lcta_pkg::cmd_t cmd
);
  import lcta_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_acc && in_kind == KIND_SOLVE) state_nxt = ST_SUM;
      ST_SUM:       if (sts.sum_done) state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = sts.balanced ? ST_INIT : ST_DONE;
      ST_INIT:      state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!sts.open_any) state_nxt = ST_DONE;
        else if (sts.scan_last) state_nxt = ST_SCAN_LAST;
      end
      ST_SCAN_LAST: state_nxt = sts.found ? ST_PICK : ST_DONE;
      ST_PICK:      state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_ACC;
      ST_ACC:       state_nxt = ST_SCAN;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load    = in_acc && in_kind != KIND_SOLVE;
        cmd.sum_clr = in_acc && in_kind == KIND_SOLVE;
      end
      ST_SUM:       cmd.sum_step = 1'b1;
      ST_CHECK:     cmd.unbal = !sts.balanced;
      ST_INIT:      cmd.init = 1'b1;
      ST_SCAN:      cmd.scan_step = sts.open_any;
      ST_SCAN_LAST: cmd.scan_step = 1'b0;
      ST_PICK:      cmd.pick = 1'b1;
      ST_MUL:       cmd.mul = 1'b1;
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      ST_DONE:      cmd = '0;
      default:      cmd = '0;
    endcase
    if (state_r == ST_INIT) cmd.scan_clr = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (state_r == ST_DONE) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== src/lcta_dp.sv =====
// Datapath: stores, balance sums, cell scan, allocation and cost total.
module lcta_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lcta_pkg::in_req_t            in_req,
  input  logic [lcta_pkg::DimW-1:0]    num_rows,
  input  logic [lcta_pkg::DimW-1:0]    num_cols,
  input  lcta_pkg::cmd_t               cmd,
  output lcta_pkg::sts_t               sts,
  output lcta_pkg::out_req_t           out_req
);
  import lcta_pkg::*;

  // Cost table memory, one write and one registered read a cycle.
  logic [AmountBits-1:0] cost_mem [0:MaxRows*MaxCols-1];
  logic [AmountBits-1:0] cost_rd_r;
  logic [AmountBits-1:0] supply_store_r [0:MaxRows-1];
  logic [AmountBits-1:0] demand_store_r [0:MaxCols-1];
  logic [AmountBits-1:0] supply_left_r  [0:MaxRows-1];
  logic [AmountBits-1:0] demand_left_r  [0:MaxCols-1];
  logic [MaxRows-1:0]    row_closed_r;
  logic [MaxCols-1:0]    col_closed_r;
  logic [DimW-1:0]       open_r_r, open_c_r;

  logic [DimW-1:0] nr, nc;
  assign nr = (num_rows > DimW'(MaxRows)) ? DimW'(MaxRows) : num_rows;
  assign nc = (num_cols > DimW'(MaxCols)) ? DimW'(MaxCols) : num_cols;

  // Balance sums
  logic [SumW-1:0] tot_s_r, tot_d_r;
  logic [DimW-1:0] sum_idx_r;

  // Scan
  logic [RowW-1:0] sr_r, br_r;
  logic [ColW-1:0] sc_r, bc_r;
  logic            scan_v_r;     // a cell read is in flight
  logic            scan_ok_r;    // cell in flight is open
  logic [RowW-1:0] pr_r;
  logic [ColW-1:0] pc_r;
  logic            found_r;
  logic [AmountBits-1:0] bcost_r, balloc_r;
  logic [AmountBits-1:0] amt_r;
  logic [TotalW-1:0]     prod_r, acc_r;
  logic [2*AmountBits-1:0] prod_w;
  logic                  status_r;
  logic                  scan_end;

  logic [CellW-1:0] rd_addr;
  logic [AmountBits-1:0] a_cur, s_cur, d_cur;

  assign scan_end = ({1'b0, sr_r} == nr - 1'b1) && ({1'b0, sc_r} == nc - 1'b1);

  always_comb begin
    if (cmd.pick) rd_addr = {br_r, bc_r};
    else          rd_addr = {sr_r, sc_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_req.kind == KIND_COST) cost_mem[{in_req.row, in_req.col}] <= in_req.value;
    cost_rd_r <= cost_mem[rd_addr];
  end

  assign s_cur = supply_left_r[pr_r];
  assign d_cur = demand_left_r[pc_r];
  assign a_cur = (s_cur < d_cur) ? s_cur : d_cur;

  // Full-width product of cost and amount.
  assign prod_w = cost_rd_r * amt_r;

  always_ff @(posedge clk) begin
    if (cmd.load && in_req.kind == KIND_SUPPLY) supply_store_r[in_req.row] <= in_req.value;
    if (cmd.load && in_req.kind == KIND_DEMAND) demand_store_r[in_req.col] <= in_req.value;

    if (cmd.sum_clr) begin
      tot_s_r   <= '0;
      tot_d_r   <= '0;
      sum_idx_r <= '0;
    end else if (cmd.sum_step) begin
      if (sum_idx_r < nr) tot_s_r <= tot_s_r + SumW'(supply_store_r[sum_idx_r[RowW-1:0]]);
      if (sum_idx_r < nc) tot_d_r <= tot_d_r + SumW'(demand_store_r[sum_idx_r[ColW-1:0]]);
      sum_idx_r <= sum_idx_r + 1'b1;
    end

    if (cmd.init) begin
      for (int i = 0; i < MaxRows; i++) supply_left_r[i] <= supply_store_r[i];
      for (int j = 0; j < MaxCols; j++) demand_left_r[j] <= demand_store_r[j];
      open_r_r <= nr;
      open_c_r <= nc;
    end

    if (cmd.scan_clr) begin
      sr_r <= '0;
      sc_r <= '0;
    end else if (cmd.scan_step) begin
      if ({1'b0, sc_r} == nc - 1'b1) begin
        sc_r <= '0;
        sr_r <= sr_r + 1'b1;
      end else begin
        sc_r <= sc_r + 1'b1;
      end
    end
    pr_r <= sr_r;
    pc_r <= sc_r;
    scan_v_r  <= cmd.scan_step;
    scan_ok_r <= !row_closed_r[sr_r] && !col_closed_r[sc_r];

    // Compare the cell read last cycle against the best so far.
    if (scan_v_r && scan_ok_r) begin
      if (!found_r || cost_rd_r < bcost_r || (cost_rd_r == bcost_r && a_cur > balloc_r)) begin
        bcost_r  <= cost_rd_r;
        balloc_r <= a_cur;
        br_r     <= pr_r;
        bc_r     <= pc_r;
      end
    end

    if (cmd.pick) begin
      if (supply_left_r[br_r] < demand_left_r[bc_r]) begin
        amt_r <= supply_left_r[br_r];
        demand_left_r[bc_r] <= demand_left_r[bc_r] - supply_left_r[br_r];
        open_r_r <= open_r_r - 1'b1;
      end else if (supply_left_r[br_r] > demand_left_r[bc_r]) begin
        amt_r <= demand_left_r[bc_r];
        supply_left_r[br_r] <= supply_left_r[br_r] - demand_left_r[bc_r];
        open_c_r <= open_c_r - 1'b1;
      end else begin
        amt_r <= supply_left_r[br_r];
        open_r_r <= open_r_r - 1'b1;
        open_c_r <= open_c_r - 1'b1;
      end
    end
    if (cmd.mul) prod_r <= TotalW'(prod_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_closed_r <= '0;
      col_closed_r <= '0;
      acc_r        <= '0;
      found_r      <= 1'b0;
      status_r     <= 1'b0;
    end else begin
      if (cmd.sum_clr) begin
        acc_r        <= '0;
        status_r     <= 1'b0;
        row_closed_r <= '0;
        col_closed_r <= '0;
      end
      if (cmd.unbal) status_r <= 1'b1;
      if (cmd.scan_clr) found_r <= 1'b0;
      else if (scan_v_r && scan_ok_r) found_r <= 1'b1;
      if (cmd.pick) begin
        if (supply_left_r[br_r] <= demand_left_r[bc_r]) row_closed_r[br_r] <= 1'b1;
        if (supply_left_r[br_r] >= demand_left_r[bc_r]) col_closed_r[bc_r] <= 1'b1;
      end
      if (cmd.acc) acc_r <= acc_r + prod_r;
    end
  end

  assign sts.sum_done  = (sum_idx_r >= nr) && (sum_idx_r >= nc);
  assign sts.balanced  = (tot_s_r == tot_d_r);
  assign sts.scan_last = scan_end;
  assign sts.found     = found_r || (scan_v_r && scan_ok_r);
  assign sts.open_any  = (open_r_r != '0) && (open_c_r != '0);

  assign out_req.total_cost = status_r ? '0 : acc_r;
  assign out_req.status     = status_r;
endmodule

// ===== src/least_cost_transport_allocation_top.sv =====
// Top level of the least-cost transport allocation block.
// Load requests: a new request can follow every cycle while no result waits.
// Solve: balance check over summed supplies and demands, then allocation
// rounds that each scan all cells through the single cost table read port.
// Synchronous active-low reset returns control to idle, dims to 1 by 1.
// The result waits in an output register until taken.
`include "assert_macros.svh"
module least_cost_transport_allocation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lcta_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lcta_pkg::out_req_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lcta_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [DimW-1:0] num_rows_r, num_cols_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DimW'(1);
      num_cols_r <= DimW'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_NUM_ROWS[0]: num_rows_r <= pwdata[DimW-1:0];
        REG_NUM_COLS[0]: num_cols_r <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_ROWS[0]: prdata = {{(32-DimW){1'b0}}, num_rows_r};
      REG_NUM_COLS[0]: prdata = {{(32-DimW){1'b0}}, num_cols_r};
      default:         prdata = '0;
    endcase
  end

  lcta_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_data.kind), .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  lcta_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_data), .num_rows(num_rows_r),
    .num_cols(num_cols_r), .cmd(cmd), .sts(sts), .out_req(out_data)
  );

  `LCTA_ASSERT_IMP(a_no_ready_while_out, clk, rst_n, out_valid, !in_ready)
  `LCTA_ASSERT_IMP(a_unbal_zero, clk, rst_n, out_valid && out_data.status, out_data.total_cost == '0)
  `LCTA_ASSERT_NEXT(a_load_no_result, clk, rst_n, in_valid && in_ready && in_data.kind != KIND_SOLVE, !out_valid)
endmodule
